// File: sv/editor_command_skip_lexer_top_defines.svh
// Assertion macros shared by the checker of the command skip lexer.
`ifndef EDITOR_COMMAND_SKIP_LEXER_TOP_DEFINES_SVH
`define EDITOR_COMMAND_SKIP_LEXER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ECSL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ECSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ecsl_pkg.sv
// Package with types and constants of the command skip lexer.
`timescale 1ns / 1ps

package ecsl_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-3:0] REG_IN_MACRO = 1'b0;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_ONE   = 4'd1;
    localparam logic [3:0] PH_DELIM = 4'd2;
    localparam logic [3:0] PH_TEXT  = 4'd3;
    localparam logic [3:0] PH_CARET = 4'd4;
    localparam logic [3:0] PH_E     = 4'd5;
    localparam logic [3:0] PH_F     = 4'd6;
    localparam logic [3:0] PH_QUOTE = 4'd7;
    localparam logic [3:0] PH_QNAME = 4'd8;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_UNTERM  = 3'd1;
    localparam logic [2:0] ERR_CARET   = 3'd2;
    localparam logic [2:0] ERR_E       = 3'd3;
    localparam logic [2:0] ERR_F       = 3'd4;
    localparam logic [2:0] ERR_QUOTE   = 3'd5;

    localparam logic [7:0] CH_CTRL_A = 8'h01;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CTRL_U = 8'h15;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_RS     = 8'h1E;

    localparam logic [4:0] CTL_A  = 5'h01;
    localparam logic [4:0] CTL_I  = 5'h09;
    localparam logic [4:0] CTL_U  = 5'h15;
    localparam logic [4:0] CTL_RS = 5'h1E;

    typedef struct packed {
        logic [7:0] ch;
        logic       buffer_end;
    } in_item_t;

    typedef struct packed {
        logic       cmd_done;
        logic [2:0] error_code;
        logic       mid_command;
    } out_item_t;

endpackage

// File: sv/editor_command_skip_lexer_top.sv
// Each byte is registered on input and its result is registered on output.
// Throughput: one byte per cycle unless the output stalls; the single
// next-state pass over phase, delimiter and prefix flags decides each byte.
// Reset: synchronous, active low; clears phase, delimiter, flags, valids
// and the in_macro register.
`timescale 1ns / 1ps

module editor_command_skip_lexer_top
    import ecsl_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic       in_valid_reg;
    in_item_t   in_data_reg;
    logic       out_valid_reg;
    out_item_t  out_data_reg;
    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic [7:0] delim_reg;
    logic [7:0] delim_next;
    logic       atsign_reg;
    logic       atsign_next;
    logic       second_reg;
    logic       second_next;
    logic       in_macro_reg;
    out_item_t  result;
    logic       advance;
    logic       cfg_write;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[CFG_ADDR_W-1:2] == REG_IN_MACRO) begin
            prdata = {{(CFG_DATA_W-1){1'b0}}, in_macro_reg};
        end
    end

    always_comb begin
        logic [7:0] c;
        logic [7:0] u;
        logic [3:0] ph;
        logic       done;
        logic [2:0] err;
        logic       start_req;
        logic [7:0] start_delim;
        logic       was_open;

        c           = in_data_reg.ch;
        u           = (c >= "a" && c <= "z") ? c - 8'd32 : c;
        ph          = (phase_reg > PH_QNAME) ? PH_IDLE : phase_reg;
        was_open    = (ph != PH_IDLE);
        phase_next  = ph;
        delim_next  = delim_reg;
        atsign_next = atsign_reg;
        second_next = second_reg;
        done        = 1'b0;
        err         = ERR_NONE;
        start_req   = 1'b0;
        start_delim = CH_ESC;

        if (in_data_reg.buffer_end) begin
            if (ph != PH_IDLE || atsign_reg) begin
                err         = in_macro_reg ? ERR_NONE : ERR_UNTERM;
                phase_next  = PH_IDLE;
                delim_next  = '0;
                atsign_next = 1'b0;
                second_next = 1'b0;
            end
        end else begin
            unique case (ph)
                PH_IDLE: begin
                    if (c == 8'h00 || (c >= 8'h0A && c <= 8'h0D) || c == " ") begin
                        done = 1'b1;
                    end else if (c == "@") begin
                        atsign_next = 1'b1;
                    end else begin
                        case (u) inside
                            CH_CTRL_A, "!": begin
                                start_req   = 1'b1;
                                start_delim = c;
                            end
                            CH_TAB, "I", "N", "O", "S", "_": begin
                                start_req = 1'b1;
                            end
                            CH_CTRL_U: phase_next = PH_QNAME;
                            CH_RS, "%", "G", "M", "Q", "U", "X", "[", "]": begin
                                phase_next = PH_ONE;
                            end
                            "\"": phase_next = PH_QUOTE;
                            "E": phase_next = PH_E;
                            "F": phase_next = PH_F;
                            "^": phase_next = PH_CARET;
                            default: done = 1'b1;
                        endcase
                    end
                end
                PH_ONE: begin
                    done = 1'b1;
                end
                PH_QNAME: begin
                    start_req = 1'b1;
                end
                PH_DELIM: begin
                    delim_next = c;
                    phase_next = PH_TEXT;
                end
                PH_TEXT: begin
                    if (c == delim_reg) begin
                        if (second_reg) begin
                            second_next = 1'b0;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
                PH_CARET: begin
                    if (u < "A" || u > "_") begin
                        err = ERR_CARET;
                    end else begin
                        case (u[4:0])
                            CTL_A: begin
                                start_req   = 1'b1;
                                start_delim = CH_CTRL_A;
                            end
                            CTL_I:   start_req = 1'b1;
                            CTL_U:   phase_next = PH_QNAME;
                            CTL_RS:  phase_next = PH_ONE;
                            default: done = 1'b1;
                        endcase
                    end
                end
                PH_E: begin
                    case (u) inside
                        "%", "Q": phase_next = PH_ONE;
                        "_", "B", "I", "G", "L", "N", "R", "W": start_req = 1'b1;
                        default: begin
                            if (u >= "A" && u <= "Z") begin
                                done = 1'b1;
                            end else begin
                                err = ERR_E;
                            end
                        end
                    endcase
                end
                PH_F: begin
                    case (u) inside
                        "C", "N", "S", "_": begin
                            second_next = 1'b1;
                            start_req   = 1'b1;
                        end
                        "B", "D", "K", "R": start_req = 1'b1;
                        "<", ">", "'", "|": done = 1'b1;
                        default: err = ERR_F;
                    endcase
                end
                PH_QUOTE: begin
                    case (u) inside
                        "<", "=", ">", "A", "C", "D", "E", "F", "G",
                        "L", "N", "R", "S", "T", "U", "V", "W": done = 1'b1;
                        default: err = ERR_QUOTE;
                    endcase
                end
                default: begin
                    done = 1'b0;
                end
            endcase

            if (start_req) begin
                if (atsign_reg) begin
                    phase_next = PH_DELIM;
                end else begin
                    delim_next = start_delim;
                    phase_next = PH_TEXT;
                end
            end

            if (err != ERR_NONE || (done && was_open)) begin
                done        = done && (err == ERR_NONE);
                phase_next  = PH_IDLE;
                delim_next  = '0;
                atsign_next = 1'b0;
                second_next = 1'b0;
            end
        end

        result.cmd_done    = done;
        result.error_code  = err;
        result.mid_command = (phase_next != PH_IDLE) || atsign_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_IDLE;
            delim_reg     <= '0;
            atsign_reg    <= 1'b0;
            second_reg    <= 1'b0;
            in_macro_reg  <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                delim_reg     <= delim_next;
                atsign_reg    <= atsign_next;
                second_reg    <= second_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write && paddr[CFG_ADDR_W-1:2] == REG_IN_MACRO) begin
                in_macro_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

endmodule

// File: sv/ecsl_checker.sv
// Port-level checker for the command skip lexer, bound to the top level.
`timescale 1ns / 1ps
`include "editor_command_skip_lexer_top_defines.svh"

module ecsl_checker
    import ecsl_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data,
    input logic      psel,
    input logic      pready
);

    `ECSL_ASSERT_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_data), "Stalled transaction changed.")
    `ECSL_ASSERT_SAME(a_error_closes, m_valid && m_data.error_code != ERR_NONE, !m_data.cmd_done && !m_data.mid_command, "An error left a command open or done.")
    `ECSL_ASSERT_SAME(a_error_range, m_valid, m_data.error_code <= ERR_QUOTE, "Error code out of range.")
    `ECSL_ASSERT_SAME(a_pready_high, psel, pready, "Register port stalled.")

endmodule

bind editor_command_skip_lexer_top ecsl_checker u_ecsl_checker (.*);
